@@ rtl/chlo_sni_pkg.sv @@
`timescale 1ns / 1ps

package chlo_sni_pkg;

  // longest server name passed on
  localparam int unsigned NAME_MAX_LEN = 255;
  localparam int unsigned NameLenW     = $clog2(NAME_MAX_LEN + 1);

  // packed header and tag table geometry
  localparam int unsigned HeaderLast   = 16;
  localparam int unsigned EntryLast    = 7;
  localparam int unsigned PosW         = 5;
  localparam int unsigned SkipW        = 34;

  // header match bytes
  localparam logic [7:0] HDR_Q   = 8'h51;
  localparam logic [7:0] HDR_T   = 8'h54;
  localparam logic [7:0] HDR_V   = 8'h56;
  localparam logic [7:0] HDR_VER = 8'h30;
  localparam logic [7:0] HDR_C   = 8'h43;
  localparam logic [7:0] HDR_H   = 8'h48;
  localparam logic [7:0] HDR_L   = 8'h4C;
  localparam logic [7:0] HDR_O   = 8'h4F;

  // tag name 'S','N','I',0 read little-endian
  localparam logic [31:0] SNI_TAG = 32'h0049_4E53;

  // verdict codes
  localparam logic [1:0] VERDICT_EXCLUDED  = 2'd0;
  localparam logic [1:0] VERDICT_DETECTED  = 2'd1;
  localparam logic [1:0] VERDICT_UNDECIDED = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAGS,
    PH_SKIP,
    PH_NAME,
    PH_DONE
  } phase_t;

  // header byte check at a given position
  function automatic logic header_byte_ok(input logic [PosW-1:0] pos, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    unique case (pos)
      5'd0:    ok = b[0];
      5'd1:    ok = (b == HDR_Q);
      5'd2:    ok = (b == HDR_T);
      5'd3:    ok = (b == HDR_V);
      5'd4:    ok = (b == HDR_VER);
      5'd9:    ok = (b == HDR_C);
      5'd10:   ok = (b == HDR_H);
      5'd11:   ok = (b == HDR_L);
      5'd12:   ok = (b == HDR_O);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

@@ rtl/chlo_handshake_sni_extractor_core.sv @@
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_ready  | payload_byte, last_byte
// output    | out_valid / out_ready| name_valid, name_byte, verdict_valid, verdict
//
// one request per cycle sustained unless the result stalls; a request passes
// through the input register, then the parse step writes the result register
// the parse step is a single pass of compares, a 32-bit subtract and a 34-bit
// add between the input register and the result register
// rst (synchronous) returns the parser to the header phase; state also
// returns there after every last byte
// a stalled result holds the parse step; the input register still takes one
// request while the result waits

module chlo_handshake_sni_extractor_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] payload_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       name_valid,
  output logic [7:0] name_byte,
  output logic       verdict_valid,
  output logic [1:0] verdict
);
  import chlo_sni_pkg::*;

  // input register
  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_last;
  logic       proc;

  // parser state
  phase_t               phase, phase_next;
  logic [PosW-1:0]      byte_pos, byte_pos_next;
  logic                 header_good, header_good_next;
  logic [15:0]          tag_total, tag_total_next;
  logic [15:0]          tags_read, tags_read_next;
  logic [55:0]          entry_shift, entry_shift_next;
  logic [31:0]          previous_end, previous_end_next;
  logic                 sni_seen, sni_seen_next;
  logic [SkipW-1:0]     value_start, value_start_next;
  logic [NameLenW-1:0]  value_length, value_length_next;
  logic [NameLenW-1:0]  bytes_sent, bytes_sent_next;

  // step outputs
  logic                 res_name_valid;
  logic [1:0]           res_verdict;
  logic                 res_any;

  // tag entry decode
  logic [31:0]          tag_name;
  logic [31:0]          tag_end;
  logic [31:0]          tag_len;
  logic [15:0]          tags_rest;

  assign proc     = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || proc;

  assign tag_name  = entry_shift[31:0];
  assign tag_end   = {inq_byte, entry_shift[55:32]};
  assign tag_len   = tag_end - previous_end;
  assign tags_rest = tag_total - tags_read_next;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      inq_byte <= payload_byte;
      inq_last <= last_byte;
    end
  end

  // next state of the parser
  always_comb begin
    phase_next        = phase;
    byte_pos_next     = byte_pos;
    header_good_next  = header_good;
    tag_total_next    = tag_total;
    tags_read_next    = tags_read;
    entry_shift_next  = entry_shift;
    previous_end_next = previous_end;
    sni_seen_next     = sni_seen;
    value_start_next  = value_start;
    value_length_next = value_length;
    bytes_sent_next   = bytes_sent;

    unique case (phase)
      PH_HEADER: begin
        if (!header_byte_ok(byte_pos, inq_byte)) header_good_next = 1'b0;
        if (byte_pos == PosW'(13)) tag_total_next[7:0]  = inq_byte;
        if (byte_pos == PosW'(14)) tag_total_next[15:8] = inq_byte;
        if (byte_pos == PosW'(HeaderLast)) begin
          byte_pos_next = '0;
          if (!header_good_next || tag_total_next == 16'd0) phase_next = PH_DONE;
          else phase_next = PH_TAGS;
        end else begin
          byte_pos_next = byte_pos + PosW'(1);
        end
      end
      PH_TAGS: begin
        entry_shift_next = {inq_byte, entry_shift[55:8]};
        if (byte_pos != PosW'(EntryLast)) begin
          byte_pos_next = byte_pos + PosW'(1);
        end else begin
          byte_pos_next  = '0;
          tags_read_next = tags_read + 16'd1;
          if (tag_name == SNI_TAG) begin
            sni_seen_next = 1'b1;
            if (tag_len > 32'(NAME_MAX_LEN)) value_length_next = NameLenW'(NAME_MAX_LEN);
            else value_length_next = tag_len[NameLenW-1:0];
            value_start_next = SkipW'({tags_rest, 3'b000}) + SkipW'(previous_end);
            if (tag_len == 32'd0) phase_next = PH_DONE;
            else if (tags_rest == 16'd0 && previous_end == 32'd0) phase_next = PH_NAME;
            else phase_next = PH_SKIP;
          end else begin
            previous_end_next = tag_end;
            if (tags_read_next >= tag_total) phase_next = PH_DONE;
          end
        end
      end
      PH_SKIP: begin
        value_start_next = value_start - SkipW'(1);
        if (value_start == SkipW'(1)) phase_next = PH_NAME;
      end
      PH_NAME: begin
        if (inq_byte == 8'd0) begin
          phase_next = PH_DONE;
        end else begin
          bytes_sent_next = bytes_sent + NameLenW'(1);
          if (bytes_sent_next >= value_length) phase_next = PH_DONE;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // step outputs: name byte flag and verdict for the last byte
  always_comb begin
    res_name_valid = (phase == PH_NAME) && (inq_byte != 8'd0);
    priority if (phase == PH_HEADER || !header_good) begin
      res_verdict = VERDICT_EXCLUDED;
    end else if (sni_seen_next) begin
      res_verdict = VERDICT_DETECTED;
    end else begin
      res_verdict = VERDICT_UNDECIDED;
    end
  end

  assign res_any = res_name_valid || inq_last;

  // parser state registers, cleared after each packet
  always_ff @(posedge clk) begin
    if (rst || (proc && inq_last)) begin
      phase        <= PH_HEADER;
      byte_pos     <= '0;
      header_good  <= 1'b1;
      tag_total    <= '0;
      tags_read    <= '0;
      entry_shift  <= '0;
      previous_end <= '0;
      sni_seen     <= 1'b0;
      value_start  <= '0;
      value_length <= '0;
      bytes_sent   <= '0;
    end else if (proc) begin
      phase        <= phase_next;
      byte_pos     <= byte_pos_next;
      header_good  <= header_good_next;
      tag_total    <= tag_total_next;
      tags_read    <= tags_read_next;
      entry_shift  <= entry_shift_next;
      previous_end <= previous_end_next;
      sni_seen     <= sni_seen_next;
      value_start  <= value_start_next;
      value_length <= value_length_next;
      bytes_sent   <= bytes_sent_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= res_any;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (proc) begin
      name_valid    <= res_name_valid;
      name_byte     <= res_name_valid ? inq_byte : 8'd0;
      verdict_valid <= inq_last;
      verdict       <= inq_last ? res_verdict : VERDICT_EXCLUDED;
    end
  end

  // a result always carries a name byte or a verdict
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (name_valid || verdict_valid))
    else $error("empty result presented");

  // the last byte of a packet leaves the parser at the header start
  assert property (@(posedge clk) disable iff (rst)
    (proc && inq_last) |=> (phase == PH_HEADER && byte_pos == '0 && !sni_seen))
    else $error("parser not cleared after last byte");

  // never more name bytes than the value length
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAME) |-> (bytes_sent < value_length))
    else $error("name overrun");

  // a name byte of zero is never passed on
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && name_valid) |-> (name_byte != 8'd0))
    else $error("zero name byte passed on");

endmodule
